// ===== hw/rtl/efhc_pkg.sv =====
// Shared constants, codes and the helper function of the Ethernet frame header classifier.
package efhc_pkg;

	// Byte at which the search for the HTTP marker starts.
	localparam logic [15:0] PAYLOAD_OFFSET = 16'd54;

	// Saturation value of the byte counter.
	localparam logic [15:0] POS_MAX = 16'hFFFF;

	// Byte positions of the header fields that are captured.
	localparam logic [15:0] POS_DMAC     = 16'd0;
	localparam logic [15:0] POS_SMAC     = 16'd6;
	localparam logic [15:0] POS_ETYPE_HI = 16'd12;
	localparam logic [15:0] POS_ETYPE_LO = 16'd13;
	localparam logic [15:0] POS_TPROTO   = 16'd23;
	localparam logic [15:0] POS_IPW      = 16'd26;
	localparam logic [15:0] POS_L4W      = 16'd34;

	// EtherType values.
	localparam logic [15:0] ETH_IPV4 = 16'h0800;
	localparam logic [15:0] ETH_ARP  = 16'h0806;
	localparam logic [15:0] ETH_RARP = 16'h8035;
	localparam logic [15:0] ETH_IPV6 = 16'h86DD;

	// IPv4 transport numbers.
	localparam logic [7:0] IPP_ICMP  = 8'd1;
	localparam logic [7:0] IPP_IGMP  = 8'd2;
	localparam logic [7:0] IPP_TCP   = 8'd6;
	localparam logic [7:0] IPP_UDP   = 8'd17;
	localparam logic [7:0] IPP_EIGRP = 8'd88;
	localparam logic [7:0] IPP_OSPF  = 8'd89;

	// Protocol value reported for an HTTP frame.
	localparam logic [15:0] HTTP_VALUE = 16'h0100;

	// Space character that separates the request line words.
	localparam logic [7:0] CHAR_SPACE = 8'h20;

	// Length of the HTTP marker in bytes.
	localparam logic [2:0] TAG_LEN = 3'd4;

	// Frame classes as reported on the result channel.
	typedef enum logic [3:0] {
		CLS_OTHER = 4'd0,
		CLS_IPV4  = 4'd1,
		CLS_ARP   = 4'd2,
		CLS_RARP  = 4'd3,
		CLS_IPV6  = 4'd4,
		CLS_ICMP  = 4'd5,
		CLS_IGMP  = 4'd6,
		CLS_TCP   = 4'd7,
		CLS_UDP   = 4'd8,
		CLS_EIGRP = 4'd9,
		CLS_OSPF  = 4'd10,
		CLS_HTTP  = 4'd11
	} class_t;

	// Character of the HTTP marker at a given index.
	function automatic logic [7:0] http_tag(input logic [1:0] idx);
		logic [7:0] ch;
		unique case (idx)
			2'd0: ch = 8'h48;
			2'd1: ch = 8'h54;
			2'd2: ch = 8'h54;
			default: ch = 8'h50;
		endcase
		return ch;
	endfunction

endpackage

// ===== hw/rtl/efhc_if.sv =====
// Channel interfaces of the classifier: the byte stream in and the result out.
interface efhc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last;

	modport source(output valid, output data_byte, output last, input ready);
	modport sink(input valid, input data_byte, input last, output ready);
endinterface

interface efhc_out_if;
	logic        valid;
	logic        ready;
	logic [47:0] dest_mac;
	logic [47:0] source_mac;
	logic [31:0] source_ip;
	logic [31:0] dest_ip;
	logic [15:0] protocol_value;
	logic [3:0]  class_code;
	logic [15:0] source_port;
	logic [15:0] dest_port;
	logic [15:0] frame_length;

	modport source(
		output valid, output dest_mac, output source_mac, output source_ip,
		output dest_ip, output protocol_value, output class_code,
		output source_port, output dest_port, output frame_length,
		input ready
	);
	modport sink(
		input valid, input dest_mac, input source_mac, input source_ip,
		input dest_ip, input protocol_value, input class_code,
		input source_port, input dest_port, input frame_length,
		output ready
	);
endinterface

// ===== hw/rtl/ethernet_frame_header_classifier.sv =====
// Top level of the Ethernet frame header classifier.
//
// Usage:
// The frame channel takes one byte of an Ethernet frame per request, starting at
// the first byte of the destination MAC, with last set on the final byte.
// The result channel gives one request per frame: MACs, IPs, ports, protocol value,
// class code and frame length. Bytes that are not last produce no result.
// A byte is registered in the input stage on acceptance and folded into the header
// state when it leaves that stage; for a last byte the result register is loaded
// at the same edge, and the result is offered from that register.
// One byte is accepted in every cycle unless a last byte is held. The only thing that holds the stream
// back is the single result register: a last byte waits in the input stage
// while an earlier result has not been taken, and other bytes pass on.
// Reset clears the byte counter, the captured header and the HTTP search,
// so the next byte accepted is the first byte of a frame. After each result
// the same state returns to zero for the next frame.
module ethernet_frame_header_classifier (
	input  logic              clk,
	input  logic              arst_n,
	efhc_in_if.sink           frame,
	efhc_out_if.source        result
);

	// Input stage.
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// Frame state.
	logic [15:0] pos_q;
	logic [47:0] dmac_q;
	logic [47:0] smac_q;
	logic [15:0] etype_q;
	logic [7:0]  tproto_q;
	logic [63:0] ipw_q;
	logic [63:0] l4w_q;
	logic [1:0]  space_cnt_q;
	logic [2:0]  match_idx_q;
	logic        search_done_q;
	logic        http_found_q;

	// Next values with the current byte folded in.
	logic [47:0] dmac_n;
	logic [47:0] smac_n;
	logic [15:0] etype_n;
	logic [7:0]  tproto_n;
	logic [63:0] ipw_n;
	logic [63:0] l4w_n;
	logic [1:0]  space_cnt_n;
	logic [2:0]  match_idx_n;
	logic        search_done_n;
	logic        http_found_n;
	logic [15:0] pos_n;

	// Classification of the finished frame.
	efhc_pkg::class_t cls_n;
	logic [15:0] pval_n;
	logic [31:0] sip_n;
	logic [31:0] dip_n;
	logic [15:0] sport_n;
	logic [15:0] dport_n;

	// Result register.
	logic             res_valid_q;
	logic [47:0]      res_dmac_q;
	logic [47:0]      res_smac_q;
	logic [31:0]      res_sip_q;
	logic [31:0]      res_dip_q;
	logic [15:0]      res_pval_q;
	efhc_pkg::class_t res_cls_q;
	logic [15:0]      res_sport_q;
	logic [15:0]      res_dport_q;
	logic [15:0]      res_len_q;

	logic res_free;
	logic adv;
	logic load_res;

	// Handshake: the input stage moves on unless a last byte meets a full result register.
	assign res_free    = !res_valid_q || result.ready;
	assign adv         = valid_s1 && (!last_s1 || res_free);
	assign load_res    = adv && last_s1;
	assign frame.ready = !valid_s1 || adv;

	// Input stage register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (frame.ready) begin
			valid_s1 <= frame.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (frame.ready && frame.valid) begin
			byte_s1 <= frame.data_byte;
			last_s1 <= frame.last;
		end
	end

	// Header capture: each field byte is written at its own position.
	always_comb begin
		dmac_n   = dmac_q;
		smac_n   = smac_q;
		etype_n  = etype_q;
		tproto_n = tproto_q;
		ipw_n    = ipw_q;
		l4w_n    = l4w_q;
		for (int i = 0; i < 6; i++) begin
			if (pos_q == efhc_pkg::POS_DMAC + 16'(i)) begin
				dmac_n[8*(5-i) +: 8] = byte_s1;
			end
			if (pos_q == efhc_pkg::POS_SMAC + 16'(i)) begin
				smac_n[8*(5-i) +: 8] = byte_s1;
			end
		end
		if (pos_q == efhc_pkg::POS_ETYPE_HI) begin
			etype_n[15:8] = byte_s1;
		end
		if (pos_q == efhc_pkg::POS_ETYPE_LO) begin
			etype_n[7:0] = byte_s1;
		end
		if (pos_q == efhc_pkg::POS_TPROTO) begin
			tproto_n = byte_s1;
		end
		for (int i = 0; i < 8; i++) begin
			if (pos_q == efhc_pkg::POS_IPW + 16'(i)) begin
				ipw_n[8*(7-i) +: 8] = byte_s1;
			end
			if (pos_q == efhc_pkg::POS_L4W + 16'(i)) begin
				l4w_n[8*(7-i) +: 8] = byte_s1;
			end
		end
		pos_n = (pos_q == efhc_pkg::POS_MAX) ? pos_q : pos_q + 16'd1;
	end

	// HTTP search: two spaces from the payload offset, then the marker.
	always_comb begin
		space_cnt_n   = space_cnt_q;
		match_idx_n   = match_idx_q;
		search_done_n = search_done_q;
		http_found_n  = http_found_q;
		if (!search_done_q && pos_q >= efhc_pkg::PAYLOAD_OFFSET) begin
			if (space_cnt_q == 2'd2) begin
				if (match_idx_q < efhc_pkg::TAG_LEN &&
					byte_s1 == efhc_pkg::http_tag(match_idx_q[1:0])) begin
					match_idx_n = match_idx_q + 3'd1;
					if (match_idx_n == efhc_pkg::TAG_LEN) begin
						http_found_n  = 1'b1;
						search_done_n = 1'b1;
					end
				end else begin
					search_done_n = 1'b1;
				end
			end else if (byte_s1 == efhc_pkg::CHAR_SPACE) begin
				space_cnt_n = space_cnt_q + 2'd1;
			end
		end
	end

	// Frame classification from the completed header.
	always_comb begin
		cls_n   = efhc_pkg::CLS_OTHER;
		pval_n  = etype_n;
		sip_n   = '0;
		dip_n   = '0;
		sport_n = '0;
		dport_n = '0;
		if (etype_n == efhc_pkg::ETH_IPV4) begin
			sip_n  = ipw_n[63:32];
			dip_n  = ipw_n[31:0];
			pval_n = {8'h00, tproto_n};
			case (tproto_n)
				efhc_pkg::IPP_ICMP:  cls_n = efhc_pkg::CLS_ICMP;
				efhc_pkg::IPP_IGMP:  cls_n = efhc_pkg::CLS_IGMP;
				efhc_pkg::IPP_TCP: begin
					cls_n   = efhc_pkg::CLS_TCP;
					sport_n = l4w_n[63:48];
					dport_n = l4w_n[47:32];
					if (http_found_n) begin
						cls_n  = efhc_pkg::CLS_HTTP;
						pval_n = efhc_pkg::HTTP_VALUE;
					end
				end
				efhc_pkg::IPP_UDP:   cls_n = efhc_pkg::CLS_UDP;
				efhc_pkg::IPP_EIGRP: cls_n = efhc_pkg::CLS_EIGRP;
				efhc_pkg::IPP_OSPF:  cls_n = efhc_pkg::CLS_OSPF;
				default:             cls_n = efhc_pkg::CLS_IPV4;
			endcase
		end else if (etype_n == efhc_pkg::ETH_ARP || etype_n == efhc_pkg::ETH_RARP) begin
			sip_n = ipw_n[47:16];
			dip_n = l4w_n[31:0];
			cls_n = (etype_n == efhc_pkg::ETH_ARP) ? efhc_pkg::CLS_ARP : efhc_pkg::CLS_RARP;
		end else if (etype_n == efhc_pkg::ETH_IPV6) begin
			cls_n = efhc_pkg::CLS_IPV6;
		end
	end

	// Frame state: updated per byte, cleared when the last byte is consumed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q         <= '0;
			dmac_q        <= '0;
			smac_q        <= '0;
			etype_q       <= '0;
			tproto_q      <= '0;
			ipw_q         <= '0;
			l4w_q         <= '0;
			space_cnt_q   <= '0;
			match_idx_q   <= '0;
			search_done_q <= 1'b0;
			http_found_q  <= 1'b0;
		end else if (adv) begin
			if (last_s1) begin
				pos_q         <= '0;
				dmac_q        <= '0;
				smac_q        <= '0;
				etype_q       <= '0;
				tproto_q      <= '0;
				ipw_q         <= '0;
				l4w_q         <= '0;
				space_cnt_q   <= '0;
				match_idx_q   <= '0;
				search_done_q <= 1'b0;
				http_found_q  <= 1'b0;
			end else begin
				pos_q         <= pos_n;
				dmac_q        <= dmac_n;
				smac_q        <= smac_n;
				etype_q       <= etype_n;
				tproto_q      <= tproto_n;
				ipw_q         <= ipw_n;
				l4w_q         <= l4w_n;
				space_cnt_q   <= space_cnt_n;
				match_idx_q   <= match_idx_n;
				search_done_q <= search_done_n;
				http_found_q  <= http_found_n;
			end
		end
	end

	// Result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load_res) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (load_res) begin
			res_dmac_q  <= dmac_n;
			res_smac_q  <= smac_n;
			res_sip_q   <= sip_n;
			res_dip_q   <= dip_n;
			res_pval_q  <= pval_n;
			res_cls_q   <= cls_n;
			res_sport_q <= sport_n;
			res_dport_q <= dport_n;
			res_len_q   <= pos_n;
		end
	end

	assign result.valid          = res_valid_q;
	assign result.dest_mac       = res_dmac_q;
	assign result.source_mac     = res_smac_q;
	assign result.source_ip      = res_sip_q;
	assign result.dest_ip        = res_dip_q;
	assign result.protocol_value = res_pval_q;
	assign result.class_code     = res_cls_q;
	assign result.source_port    = res_sport_q;
	assign result.dest_port      = res_dport_q;
	assign result.frame_length   = res_len_q;

`ifndef NO_ASSERTIONS
	// An HTTP result always carries the HTTP protocol value.
	a_http_value: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_cls_q == efhc_pkg::CLS_HTTP |-> res_pval_q == efhc_pkg::HTTP_VALUE)
		else $error("HTTP result without HTTP protocol value");

	// Ports are reported only for TCP and HTTP frames.
	a_ports_tcp: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !(res_cls_q == efhc_pkg::CLS_TCP || res_cls_q == efhc_pkg::CLS_HTTP)
		|-> res_sport_q == '0 && res_dport_q == '0)
		else $error("ports reported for a non-TCP frame");

	// After a result the next frame starts at byte zero.
	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		load_res |=> pos_q == '0 && !search_done_q && res_valid_q)
		else $error("frame state not cleared after result");

	// Every frame holds at least one byte.
	a_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> res_len_q != '0)
		else $error("result with zero frame length");
`endif

endmodule

// ===== bench/tb_top.sv =====
// Self-checking testbench of the Ethernet frame header classifier, with its own frame predictor.
`timescale 1ns / 1ps

module tb_top;

	// EtherType with the first two digits of RARP swapped, which must be reported as unknown.
	localparam logic [15:0] ETH_RARP_MISREAD = 16'h0835;
	// Marker that follows the second space of an HTTP request line.
	localparam logic [31:0] HTTP_MARK = "HTTP";

	typedef enum int {
		HUNT_NONE,
		HUNT_GOOD,
		HUNT_BROKEN
	} hunt_mode_t;

	typedef struct {
		logic [47:0]      dest_mac;
		logic [47:0]      source_mac;
		logic [31:0]      source_ip;
		logic [31:0]      dest_ip;
		logic [15:0]      protocol_value;
		efhc_pkg::class_t class_code;
		logic [15:0]      source_port;
		logic [15:0]      dest_port;
		logic [15:0]      frame_length;
	} frame_summary_t;

	logic clk;
	logic arst_n;

	efhc_in_if  u_frame_if();
	efhc_out_if u_result_if();

	ethernet_frame_header_classifier u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.frame  (u_frame_if),
		.result (u_result_if)
	);

	// Predictor state: position in the frame, header words and the HTTP search.
	logic [15:0] frame_pos;
	logic [63:0] hdr_words [4];
	logic [1:0]  spaces_seen;
	logic [2:0]  tag_idx;
	logic        hunt_over;
	logic        http_seen;

	frame_summary_t expected_summaries[$];
	frame_summary_t want_summary;
	logic [7:0]     frame_buf[$];
	int             mark_end;
	int             fail_count = 0;
	bit             quiet;

	// Clock with a 12 ns period.
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// The result side stalls at random about 30 percent of the time, except in quiet stretches.
	always @(negedge clk) begin
		u_result_if.ready <= quiet ? 1'b1 : ($urandom_range(99) >= 30);
	end

	task automatic clear_tracker();
		frame_pos = '0;
		for (int i = 0; i < 4; i++) hdr_words[i] = '0;
		spaces_seen = '0;
		tag_idx = '0;
		hunt_over = 1'b0;
		http_seen = 1'b0;
	endtask

	// Folds one accepted byte into the predicted header and, on the last byte,
	// queues the summary that the block should report for the frame.
	task automatic track_frame_byte(input logic [7:0] b, input logic l);
		int             p;
		frame_summary_t s;
		logic [15:0]    etype;
		logic [7:0]     tproto;

		p = int'(frame_pos);
		if (p == 0) clear_tracker();

		// Header capture.
		if (p <= 5) begin
			hdr_words[0][8*(7-p) +: 8] = b;
		end else if (p <= 11) begin
			hdr_words[1][8*(13-p) +: 8] = b;
		end else if (p == efhc_pkg::POS_ETYPE_HI) begin
			hdr_words[0][15:8] = b;
		end else if (p == efhc_pkg::POS_ETYPE_LO) begin
			hdr_words[0][7:0] = b;
		end else if (p == efhc_pkg::POS_TPROTO) begin
			hdr_words[1][7:0] = b;
		end else if (p >= efhc_pkg::POS_IPW && p <= 33) begin
			hdr_words[2][8*(33-p) +: 8] = b;
		end else if (p >= efhc_pkg::POS_L4W && p <= 41) begin
			hdr_words[3][8*(41-p) +: 8] = b;
		end

		// HTTP search: two spaces, then the four marker characters in a row.
		if (!hunt_over && p >= efhc_pkg::PAYLOAD_OFFSET) begin
			if (spaces_seen >= 2) begin
				if (tag_idx < 4 && b == HTTP_MARK[8*(3-int'(tag_idx)) +: 8]) begin
					tag_idx = tag_idx + 3'd1;
					if (tag_idx >= 4) begin
						http_seen = 1'b1;
						hunt_over = 1'b1;
					end
				end else begin
					hunt_over = 1'b1;
				end
			end else if (b == efhc_pkg::CHAR_SPACE) begin
				spaces_seen = spaces_seen + 2'd1;
			end
		end

		if (frame_pos != efhc_pkg::POS_MAX) frame_pos = frame_pos + 16'd1;

		if (l) begin
			etype = hdr_words[0][15:0];
			tproto = hdr_words[1][7:0];
			s.dest_mac = hdr_words[0][63:16];
			s.source_mac = hdr_words[1][63:16];
			s.source_ip = '0;
			s.dest_ip = '0;
			s.source_port = '0;
			s.dest_port = '0;
			s.protocol_value = etype;
			s.class_code = efhc_pkg::CLS_OTHER;
			s.frame_length = frame_pos;
			if (etype == efhc_pkg::ETH_IPV4) begin
				s.source_ip = hdr_words[2][63:32];
				s.dest_ip = hdr_words[2][31:0];
				s.protocol_value = {8'h00, tproto};
				case (tproto)
					efhc_pkg::IPP_ICMP: s.class_code = efhc_pkg::CLS_ICMP;
					efhc_pkg::IPP_IGMP: s.class_code = efhc_pkg::CLS_IGMP;
					efhc_pkg::IPP_TCP: begin
						s.class_code = efhc_pkg::CLS_TCP;
						s.source_port = hdr_words[3][63:48];
						s.dest_port = hdr_words[3][47:32];
						if (http_seen) begin
							s.class_code = efhc_pkg::CLS_HTTP;
							s.protocol_value = efhc_pkg::HTTP_VALUE;
						end
					end
					efhc_pkg::IPP_UDP: s.class_code = efhc_pkg::CLS_UDP;
					efhc_pkg::IPP_EIGRP: s.class_code = efhc_pkg::CLS_EIGRP;
					efhc_pkg::IPP_OSPF: s.class_code = efhc_pkg::CLS_OSPF;
					default: s.class_code = efhc_pkg::CLS_IPV4;
				endcase
			end else if (etype == efhc_pkg::ETH_ARP || etype == efhc_pkg::ETH_RARP) begin
				s.source_ip = hdr_words[2][47:16];
				s.dest_ip = hdr_words[3][31:0];
				s.class_code = (etype == efhc_pkg::ETH_ARP) ? efhc_pkg::CLS_ARP
					: efhc_pkg::CLS_RARP;
			end else if (etype == efhc_pkg::ETH_IPV6) begin
				s.class_code = efhc_pkg::CLS_IPV6;
			end
			expected_summaries.push_back(s);
			clear_tracker();
		end
	endtask

	task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
		if (got !== want) begin
			fail_count++;
			$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
		end
	endtask

	// Every accepted result is compared with the oldest pending frame summary.
	always @(posedge clk) begin
		if (arst_n && u_result_if.valid && u_result_if.ready) begin
			if (expected_summaries.size() == 0) begin
				fail_count++;
				$display("%0t: result with no frame pending, expected none, actual class %0d",
					$time, u_result_if.class_code);
			end else begin
				want_summary = expected_summaries.pop_front();
				check_field("dest_mac", 64'(want_summary.dest_mac),
					64'(u_result_if.dest_mac));
				check_field("source_mac", 64'(want_summary.source_mac),
					64'(u_result_if.source_mac));
				check_field("source_ip", 64'(want_summary.source_ip),
					64'(u_result_if.source_ip));
				check_field("dest_ip", 64'(want_summary.dest_ip),
					64'(u_result_if.dest_ip));
				check_field("protocol_value", 64'(want_summary.protocol_value),
					64'(u_result_if.protocol_value));
				check_field("class_code", 64'(want_summary.class_code),
					64'(u_result_if.class_code));
				check_field("source_port", 64'(want_summary.source_port),
					64'(u_result_if.source_port));
				check_field("dest_port", 64'(want_summary.dest_port),
					64'(u_result_if.dest_port));
				check_field("frame_length", 64'(want_summary.frame_length),
					64'(u_result_if.frame_length));
			end
		end
	end

	// Offers one byte at a falling edge, with a random gap before it, and waits
	// until the request is taken.
	task automatic push_byte(input logic [7:0] b, input logic l);
		if (!quiet && $urandom_range(99) < 30) begin
			u_frame_if.valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		u_frame_if.valid <= 1'b1;
		u_frame_if.data_byte <= b;
		u_frame_if.last <= l;
		@(posedge clk);
		while (!u_frame_if.ready) @(posedge clk);
		track_frame_byte(b, l);
		@(negedge clk);
	endtask

	task automatic send_frame();
		foreach (frame_buf[i]) push_byte(frame_buf[i], i == frame_buf.size() - 1);
	endtask

	// Builds a frame of random bytes with the given EtherType and transport
	// number, and optionally a request line with the HTTP marker at the payload.
	task automatic fill_frame(input logic [15:0] etype, input logic [7:0] tproto,
			input int len, input hunt_mode_t mode);
		logic [7:0] mark[$];
		logic [7:0] c;
		int         n;
		int         bad;

		frame_buf.delete();
		for (int i = 0; i < len; i++) frame_buf.push_back(8'($urandom_range(255)));
		if (len > efhc_pkg::POS_ETYPE_HI) frame_buf[efhc_pkg::POS_ETYPE_HI] = etype[15:8];
		if (len > efhc_pkg::POS_ETYPE_LO) frame_buf[efhc_pkg::POS_ETYPE_LO] = etype[7:0];
		if (len > efhc_pkg::POS_TPROTO) frame_buf[efhc_pkg::POS_TPROTO] = tproto;
		if (mode != HUNT_NONE) begin
			repeat (2) begin
				n = $urandom_range(0, 5);
				repeat (n) begin
					do c = 8'($urandom_range(255)); while (c == efhc_pkg::CHAR_SPACE);
					mark.push_back(c);
				end
				mark.push_back(efhc_pkg::CHAR_SPACE);
			end
			for (int k = 0; k < 4; k++) mark.push_back(HTTP_MARK[8*(3-k) +: 8]);
			if (mode == HUNT_BROKEN) begin
				bad = $urandom_range(mark.size() - 4, mark.size() - 1);
				mark[bad] = mark[bad] ^ 8'h01;
			end
			mark_end = efhc_pkg::PAYLOAD_OFFSET + mark.size();
			foreach (mark[k]) begin
				if (efhc_pkg::PAYLOAD_OFFSET + k < len) begin
					frame_buf[efhc_pkg::PAYLOAD_OFFSET + k] = mark[k];
				end
			end
		end
	endtask

	// Every EtherType and IPv4 transport that the block tells apart.
	task automatic test_ethertypes();
		logic [7:0]  protos [7];
		logic [15:0] etypes [5];

		protos = '{efhc_pkg::IPP_ICMP, efhc_pkg::IPP_IGMP, efhc_pkg::IPP_TCP,
			efhc_pkg::IPP_UDP, efhc_pkg::IPP_EIGRP, efhc_pkg::IPP_OSPF, 8'hFF};
		etypes = '{efhc_pkg::ETH_ARP, efhc_pkg::ETH_RARP, ETH_RARP_MISREAD,
			efhc_pkg::ETH_IPV6, 16'h0000};
		foreach (protos[i]) begin
			fill_frame(efhc_pkg::ETH_IPV4, protos[i], 48, HUNT_NONE);
			send_frame();
		end
		foreach (etypes[i]) begin
			fill_frame(etypes[i], 8'h00, 48, HUNT_NONE);
			send_frame();
		end
	endtask

	// Frames of all zeros and all ones, with and without a known header.
	task automatic test_field_extremes();
		logic [15:0] etypes [3];

		etypes = '{16'hFFFF, efhc_pkg::ETH_IPV4, efhc_pkg::ETH_ARP};
		fill_frame(16'h0000, 8'h00, 48, HUNT_NONE);
		foreach (frame_buf[i]) frame_buf[i] = 8'h00;
		send_frame();
		foreach (etypes[j]) begin
			fill_frame(etypes[j], efhc_pkg::IPP_TCP, 48, HUNT_NONE);
			foreach (frame_buf[i]) frame_buf[i] = 8'hFF;
			frame_buf[efhc_pkg::POS_ETYPE_HI] = etypes[j][15:8];
			frame_buf[efhc_pkg::POS_ETYPE_LO] = etypes[j][7:0];
			frame_buf[efhc_pkg::POS_TPROTO] = efhc_pkg::IPP_TCP;
			send_frame();
		end
	endtask

	// Frames that end inside the header or just after it, so that missing fields read as zero.
	task automatic test_short_frames();
		int lens [8];

		lens = '{1, 12, 13, 14, 24, 30, 38, 42};
		foreach (lens[i]) begin
			fill_frame(efhc_pkg::ETH_IPV4, efhc_pkg::IPP_TCP, lens[i], HUNT_NONE);
			send_frame();
		end
		fill_frame(efhc_pkg::ETH_ARP, 8'h00, 30, HUNT_NONE);
		send_frame();
	endtask

	// The HTTP marker whole, cut off, broken, on a frame that is not TCP, and absent from a TCP payload.
	task automatic test_http_marker();
		fill_frame(efhc_pkg::ETH_IPV4, efhc_pkg::IPP_TCP, 72, HUNT_GOOD);
		send_frame();
		for (int k = 0; k < 4; k++) begin
			fill_frame(efhc_pkg::ETH_IPV4, efhc_pkg::IPP_TCP, 120, HUNT_GOOD);
			while (frame_buf.size() > mark_end - k) void'(frame_buf.pop_back());
			send_frame();
		end
		fill_frame(efhc_pkg::ETH_IPV4, efhc_pkg::IPP_TCP, 72, HUNT_BROKEN);
		send_frame();
		fill_frame(efhc_pkg::ETH_IPV4, efhc_pkg::IPP_UDP, 72, HUNT_GOOD);
		send_frame();
		fill_frame(efhc_pkg::ETH_IPV4, efhc_pkg::IPP_TCP, 72, HUNT_NONE);
		for (int i = efhc_pkg::PAYLOAD_OFFSET; i < 72; i++) frame_buf[i] = "A";
		send_frame();
	endtask

	// Mostly well-formed frames with random content, the rest noise and
	// truncated headers. A stretch in the middle runs with no idling.
	task automatic test_random_traffic();
		int          rnd_bytes;
		int          rnd_frames;
		int          len;
		int          pick;
		logic [15:0] etype;
		logic [7:0]  tproto;
		hunt_mode_t  mode;

		rnd_bytes = 0;
		rnd_frames = 0;
		while (rnd_bytes < 400 || rnd_frames < 8) begin
			quiet = (rnd_frames >= 2 && rnd_frames < 6);
			mode = HUNT_NONE;
			etype = efhc_pkg::ETH_IPV4;
			tproto = 8'($urandom_range(255));
			len = $urandom_range(42, 90);
			pick = $urandom_range(99);
			if (pick < 20) begin
				etype = 16'($urandom_range(16'hFFFF));
				len = $urandom_range(1, 70);
			end else if (pick < 25) begin
				case ($urandom_range(2))
					0: etype = efhc_pkg::ETH_ARP;
					1: etype = efhc_pkg::ETH_RARP;
					default: etype = efhc_pkg::ETH_IPV4;
				endcase
				len = $urandom_range(1, 41);
			end else if (pick < 60) begin
				tproto = efhc_pkg::IPP_TCP;
				mode = ($urandom_range(99) < 60) ? HUNT_GOOD : hunt_mode_t'($urandom_range(2));
				len = $urandom_range(58, 90);
			end else if (pick < 80) begin
				case ($urandom_range(5))
					0: tproto = efhc_pkg::IPP_ICMP;
					1: tproto = efhc_pkg::IPP_IGMP;
					2: tproto = efhc_pkg::IPP_UDP;
					3: tproto = efhc_pkg::IPP_EIGRP;
					4: tproto = efhc_pkg::IPP_OSPF;
					default: ;
				endcase
			end else begin
				case ($urandom_range(3))
					0: etype = efhc_pkg::ETH_ARP;
					1: etype = efhc_pkg::ETH_RARP;
					2: etype = efhc_pkg::ETH_IPV6;
					default: etype = ETH_RARP_MISREAD;
				endcase
			end
			fill_frame(etype, tproto, len, mode);
			send_frame();
			rnd_bytes += len;
			rnd_frames++;
		end
		quiet = 1'b0;
	endtask

	initial begin
		u_frame_if.valid = 1'b0;
		u_frame_if.data_byte = 8'h00;
		u_frame_if.last = 1'b0;
		arst_n = 1'b0;
		quiet = 1'b0;
		mark_end = 0;
		clear_tracker();
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		test_ethertypes();
		test_field_extremes();
		test_short_frames();
		test_http_marker();
		test_random_traffic();

		u_frame_if.valid <= 1'b0;
		wait (expected_summaries.size() == 0);
		repeat (8) @(posedge clk);
		if (fail_count == 0) begin
			$display("ethernet_frame_header_classifier regression: pass");
		end else begin
			$display("ethernet_frame_header_classifier regression: fail");
		end
		$finish;
	end

	// Watchdog against a stalled handshake.
	initial begin
		#1_000_000;
		$display("ethernet_frame_header_classifier regression: fail");
		$finish;
	end

endmodule
